[rtl/core/utdq_pkg.sv]
// Shared types and constants for the up-to-direction quaternion block.
`default_nettype none
package utdq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int DIR_W     = 16;                 // input component width
  localparam int OUT_W     = 16;                 // output component width
  localparam int MARGIN_W  = 11;
  localparam int DEN_W     = 32;                 // holds x^2+y^2+z^2 and the second-pass sum
  localparam int QB        = 2 * FRAC_BITS + 1;  // quotient bits of k^2*2^(2F)/den
  localparam int RB        = FRAC_BITS + 1;      // root bits
  localparam int RAD_W     = 2 * RB;             // radicand width
  localparam int CNT_W     = $clog2(QB);
  localparam int Q_DEPTH   = 4;
  localparam int Q_IDX_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CODE_GENERAL  = 2'd0,
    CODE_ALIGNED  = 2'd1,
    CODE_OPPOSITE = 2'd2,
    CODE_ZERO     = 2'd3
  } case_code_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
    logic [DEN_W-1:0]        n2;
    logic                    zero;
  } utdq_item_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_DIV,
    SC_SQRT
  } utdq_scale_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RUN1,
    B_SQR,
    B_ADD,
    B_RUN2
  } utdq_back_state_t;

  function automatic logic [DIR_W-1:0] abs_dir(input logic signed [DIR_W-1:0] v);
    abs_dir = v[DIR_W-1] ? DIR_W'(-v) : DIR_W'(v);
  endfunction

endpackage
`default_nettype wire

[rtl/core/up_to_direction_quaternion_top.sv]
// Top level of the up-to-direction quaternion block.
//
//   channel  handshake        payload
//   request  start / busy     dir_x, dir_y, dir_z
//   result   done (strobe)    quat_x, quat_y, quat_z, quat_w, case_code
//   config   cfg_we           cfg_data (parallel_margin)
//
// A request is registered in the square stage, then waits in a four-entry queue.
// The back part runs a general request through two passes of the bit-serial divide
// and root units; aligned and opposite requests take one pass, zero requests none.
// Reset clears the margin, the queue and all control state; no clearing pass.
// busy rises when the queue has no slot left; results cannot be stalled.
`default_nettype none
module up_to_direction_quaternion_top
  import utdq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [DIR_W-1:0] dir_x,
  input  wire logic signed [DIR_W-1:0] dir_y,
  input  wire logic signed [DIR_W-1:0] dir_z,
  input  wire logic                    cfg_we,
  input  wire logic [MARGIN_W-1:0]     cfg_data,
  output logic                         done,
  output logic signed [OUT_W-1:0]      quat_x,
  output logic signed [OUT_W-1:0]      quat_y,
  output logic signed [OUT_W-1:0]      quat_z,
  output logic signed [OUT_W-1:0]      quat_w,
  output logic [1:0]                   case_code
);

  logic [MARGIN_W-1:0] parallel_margin;
  logic                push, pop, empty;
  utdq_item_t          wdata, rdata;
  logic [Q_CNT_W-1:0]  q_count;

  always_ff @(posedge clk) begin
    if (rst) parallel_margin <= '0;
    else if (cfg_we) parallel_margin <= cfg_data;
  end

  utdq_front u_front (
    .clk, .rst, .start, .dir_x, .dir_y, .dir_z,
    .q_count, .busy, .push, .item(wdata)
  );

  utdq_queue u_queue (
    .clk, .rst, .push, .wdata, .pop, .rdata, .empty, .count(q_count)
  );

  utdq_back u_back (
    .clk, .rst, .empty, .item(rdata), .margin(parallel_margin),
    .pop, .done, .quat_x, .quat_y, .quat_z, .quat_w, .case_code
  );

endmodule
`default_nettype wire

[rtl/core/utdq_queue.sv]
// Small register queue between the front and back parts.
`default_nettype none
module utdq_queue
  import utdq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire utdq_item_t wdata,
  input  wire logic       pop,
  output utdq_item_t      rdata,
  output logic            empty,
  output logic [Q_CNT_W-1:0] count
);

  utdq_item_t mem [Q_DEPTH];
  logic [Q_IDX_W-1:0] wr_ptr;
  logic [Q_IDX_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  assign rdata = mem[rd_ptr];
  assign empty = (count == '0);

endmodule
`default_nettype wire

[rtl/core/utdq_front.sv]
// Front part: takes requests, squares the components, forms the squared norm and flags zero.
`default_nettype none
module utdq_front
  import utdq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [DIR_W-1:0] dir_x,
  input  wire logic signed [DIR_W-1:0] dir_y,
  input  wire logic signed [DIR_W-1:0] dir_z,
  input  wire logic [Q_CNT_W-1:0]      q_count,
  output logic                         busy,
  output logic                         push,
  output utdq_item_t                   item
);

  logic                    fv;
  logic signed [DIR_W-1:0] fx, fy, fz;
  logic [DEN_W-1:0]        sqx, sqy, sqz;
  logic [DEN_W-1:0]        n2;

  // Reserve a queue slot for the request held in the square stage.
  assign busy = (Q_CNT_W'(q_count) + Q_CNT_W'(fv)) >= Q_CNT_W'(Q_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) fv <= 1'b0;
    else fv <= start && !busy;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      fx  <= dir_x;
      fy  <= dir_y;
      fz  <= dir_z;
      sqx <= DEN_W'(abs_dir(dir_x)) * DEN_W'(abs_dir(dir_x));
      sqy <= DEN_W'(abs_dir(dir_y)) * DEN_W'(abs_dir(dir_y));
      sqz <= DEN_W'(abs_dir(dir_z)) * DEN_W'(abs_dir(dir_z));
    end
  end

  assign n2   = sqx + sqy + sqz;
  assign push = fv;

  always_comb begin
    item.x    = fx;
    item.y    = fy;
    item.z    = fz;
    item.n2   = n2;
    item.zero = (n2 == '0);
  end

endmodule
`default_nettype wire

[rtl/core/utdq_scale.sv]
// Bit-serial unit: m = floor(sqrt(floor(k^2 * 2^(2F) / den))).
`default_nettype none
module utdq_scale
  import utdq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIR_W-1:0] kmag,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [RB-1:0]         m
);

  utdq_scale_state_t state, state_next;
  logic [CNT_W-1:0]  cnt;
  logic [DEN_W:0]    r;
  logic [DEN_W-1:0]  d;
  logic [QB-1:0]     q;
  logic [DEN_W+1:0]  t;
  logic              ge;
  logic [DEN_W+1:0]  t_sub;
  logic [QB-1:0]     q_next;
  logic [RAD_W-1:0]  n;
  logic [RAD_W-1:0]  root;
  logic [RAD_W-1:0]  bitv;
  logic [RAD_W:0]    cmp;
  logic              take;

  // First quotient step uses the remainder unshifted (k^2 <= den).
  assign t      = (cnt == CNT_W'(QB - 1)) ? {1'b0, r} : {r, 1'b0};
  assign ge     = t >= {2'b00, d};
  assign t_sub  = t - {2'b00, d};
  assign q_next = {q[QB-2:0], ge};
  assign cmp    = {1'b0, root} + {1'b0, bitv};
  assign take   = {1'b0, n} >= cmp;

  always_comb begin
    state_next = state;
    unique case (state)
      SC_IDLE: if (start) state_next = SC_DIV;
      SC_DIV:  if (cnt == '0) state_next = SC_SQRT;
      SC_SQRT: if (cnt == '0) state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == SC_SQRT) && (cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SC_IDLE: begin
        if (start) begin
          r   <= (DEN_W + 1)'(kmag) * (DEN_W + 1)'(kmag);
          d   <= den;
          q   <= '0;
          cnt <= CNT_W'(QB - 1);
        end
      end
      SC_DIV: begin
        r <= ge ? t_sub[DEN_W:0] : t[DEN_W:0];
        q <= q_next;
        if (cnt == '0) begin
          n    <= RAD_W'(q_next);
          root <= '0;
          bitv <= RAD_W'(1) << (2 * (RB - 1));
          cnt  <= CNT_W'(RB - 1);
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      SC_SQRT: begin
        if (take) begin
          n    <= n - cmp[RAD_W-1:0];
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  assign m = root[RB-1:0];

endmodule
`default_nettype wire

[rtl/core/utdq_back.sv]
// Back part: normalizes the direction, classifies the cosine, builds the quaternion.
`default_nettype none
module utdq_back
  import utdq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  empty,
  input  wire utdq_item_t            item,
  input  wire logic [MARGIN_W-1:0]   margin,
  output logic                       pop,
  output logic                       done,
  output logic signed [OUT_W-1:0]    quat_x,
  output logic signed [OUT_W-1:0]    quat_y,
  output logic signed [OUT_W-1:0]    quat_z,
  output logic signed [OUT_W-1:0]    quat_w,
  output logic [1:0]                 case_code
);

  utdq_back_state_t state, state_next;

  logic             st;
  logic [DIR_W-1:0] k0, k1, k2;
  logic [DEN_W-1:0] den;
  logic             d0, d1, d2;
  logic [RB-1:0]    m0, m1, m2;

  logic             neg_x, neg_y, neg_z;
  logic signed [OUT_W-1:0] tx, tz, w;
  logic [DEN_W-1:0] sq_tx, sq_tz, sq_w, m2sum;

  logic signed [OUT_W-1:0] c;
  logic signed [OUT_W:0]   hi, lo;
  logic             aligned, opposite;
  logic             load;
  case_code_t       code_sel;
  logic signed [OUT_W-1:0] qx_sel, qz_sel, qw_sel;

  function automatic logic signed [OUT_W-1:0] apply_sign(input logic neg,
                                                        input logic [RB-1:0] mag);
    apply_sign = neg ? -OUT_W'(mag) : OUT_W'(mag);
  endfunction

  utdq_scale u_sc0 (.clk, .rst, .start(st), .kmag(k0), .den, .done(d0), .m(m0));
  utdq_scale u_sc1 (.clk, .rst, .start(st), .kmag(k1), .den, .done(d1), .m(m1));
  utdq_scale u_sc2 (.clk, .rst, .start(st), .kmag(k2), .den, .done(d2), .m(m2));

  assign c        = apply_sign(neg_y, m1);
  assign hi       = (OUT_W + 1)'(ONE) - (OUT_W + 1)'(margin);
  assign lo       = (OUT_W + 1)'(margin) - (OUT_W + 1)'(ONE);
  assign aligned  = (OUT_W + 1)'(c) >= hi;
  assign opposite = (OUT_W + 1)'(c) <= lo;
  assign m2sum    = sq_tx + sq_tz + sq_w;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!empty && !item.zero) state_next = B_RUN1;
      B_RUN1: begin
        if (d0 && d1 && d2) state_next = (aligned || opposite) ? B_IDLE : B_SQR;
      end
      B_SQR:  state_next = B_ADD;
      B_ADD:  state_next = B_RUN2;
      B_RUN2: if (d0 && d1 && d2) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    st       = 1'b0;
    load     = 1'b0;
    k0       = abs_dir(item.x);
    k1       = abs_dir(item.y);
    k2       = abs_dir(item.z);
    den      = item.n2;
    code_sel = CODE_GENERAL;
    qx_sel   = '0;
    qz_sel   = '0;
    qw_sel   = OUT_W'(ONE);
    unique case (state)
      B_IDLE: begin
        pop = !empty;
        st  = !empty && !item.zero;
        if (!empty && item.zero) begin
          load     = 1'b1;
          code_sel = CODE_ZERO;
        end
      end
      B_RUN1: begin
        if (d0 && d1 && d2) begin
          if (aligned) begin
            load     = 1'b1;
            code_sel = CODE_ALIGNED;
          end else if (opposite) begin
            load     = 1'b1;
            code_sel = CODE_OPPOSITE;
            qx_sel   = OUT_W'(ONE);
            qw_sel   = '0;
          end
        end
      end
      B_ADD: begin
        st  = 1'b1;
        k0  = abs_dir(tz);
        k1  = abs_dir(tx);
        k2  = DIR_W'(w);
        den = m2sum;
      end
      B_RUN2: begin
        if (d0 && d1 && d2) begin
          load     = 1'b1;
          code_sel = CODE_GENERAL;
          qx_sel   = apply_sign(tz[OUT_W-1], m0);
          qz_sel   = apply_sign(!tx[OUT_W-1], m1);
          qw_sel   = OUT_W'(m2);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (st && state == B_IDLE) begin
      neg_x <= item.x[DIR_W-1];
      neg_y <= item.y[DIR_W-1];
      neg_z <= item.z[DIR_W-1];
    end
    if (state == B_RUN1 && d0 && d1 && d2) begin
      tx <= apply_sign(neg_x, m0);
      tz <= apply_sign(neg_z, m2);
      w  <= OUT_W'(ONE) + c;
    end
    if (state == B_SQR) begin
      sq_tx <= DEN_W'(abs_dir(tx)) * DEN_W'(abs_dir(tx));
      sq_tz <= DEN_W'(abs_dir(tz)) * DEN_W'(abs_dir(tz));
      sq_w  <= DEN_W'($unsigned(w)) * DEN_W'($unsigned(w));
    end
    if (load) begin
      quat_x    <= qx_sel;
      quat_z    <= qz_sel;
      quat_w    <= qw_sel;
      case_code <= code_sel;
    end
  end

  assign quat_y = '0;

endmodule
`default_nettype wire

[bench/tb_up_to_direction_quaternion_top.sv]
// Testbench for the up-to-direction quaternion block: random and directed requests.
`timescale 1ns / 100ps
`default_nettype none

class quat_scoreboard;
  typedef struct {
    logic signed [15:0] qx, qy, qz, qw;
    logic [1:0]         code;
  } quat_t;

  quat_t       pending[$];
  int unsigned margin;
  int          mismatches;
  int          unmatched;
  int          checked;
  int          per_code[4];

  function new();
    margin = 0;
    mismatches = 0;
    unmatched = 0;
    checked = 0;
  endfunction

  // floor(num * 2^sh / den), bit by bit
  static function longint unsigned div_shift(longint unsigned num, int sh,
                                             longint unsigned den);
    longint unsigned q, r;
    q = num / den;
    r = num % den;
    for (int i = 0; i < sh; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  static function longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  static function longint over_root(longint k, longint unsigned den);
    longint unsigned mag, m;
    mag = k < 0 ? -k : k;
    m = int_root(div_shift(mag * mag, 2 * utdq_pkg::FRAC_BITS, den));
    return k < 0 ? -longint'(m) : longint'(m);
  endfunction

  function void note_request(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    quat_t           e;
    longint          one, c, tx, tz, w, xs, ys, zs;
    longint unsigned n2, m2;
    one = utdq_pkg::ONE;
    xs = x;
    ys = y;
    zs = z;
    n2 = xs * xs + ys * ys + zs * zs;
    e.qx = 0; e.qy = 0; e.qz = 0; e.qw = 16'(one);
    if (n2 == 0) begin
      e.code = utdq_pkg::CODE_ZERO;
    end else begin
      c = over_root(ys, n2);
      if (c >= one - longint'(margin)) begin
        e.code = utdq_pkg::CODE_ALIGNED;
      end else if (c <= -one + longint'(margin)) begin
        e.code = utdq_pkg::CODE_OPPOSITE;
        e.qx = 16'(one);
        e.qw = 0;
      end else begin
        tx = over_root(xs, n2);
        tz = over_root(zs, n2);
        w = one + c;
        m2 = tz * tz + tx * tx + w * w;
        e.code = utdq_pkg::CODE_GENERAL;
        e.qx = 16'(over_root(tz, m2));
        e.qz = 16'(over_root(-tx, m2));
        e.qw = 16'(over_root(w, m2));
      end
    end
    pending.push_back(e);
  endfunction

  function void check_result(logic signed [15:0] qx, logic signed [15:0] qy,
                             logic signed [15:0] qz, logic signed [15:0] qw,
                             logic [1:0] code);
    quat_t e;
    if (pending.size() == 0) begin
      unmatched++;
      if (mismatches + unmatched <= 10)
        $display("unexpected result %0d %0d %0d %0d code %0d", qx, qy, qz, qw, code);
      return;
    end
    e = pending.pop_front();
    checked++;
    per_code[e.code]++;
    if (e.qx !== qx || e.qy !== qy || e.qz !== qz || e.qw !== qw || e.code !== code) begin
      mismatches++;
      if (mismatches + unmatched <= 10)
        $display("mismatch: expected %0d %0d %0d %0d code %0d, got %0d %0d %0d %0d code %0d",
                 e.qx, e.qy, e.qz, e.qw, e.code, qx, qy, qz, qw, code);
    end
  endfunction
endclass

module tb_up_to_direction_quaternion_top;
  import utdq_pkg::*;

  localparam int WATCH_LIMIT = 20000;

  logic                    clk, rst, start, cfg_we;
  logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;
  logic [MARGIN_W-1:0]     cfg_data;
  logic                    busy, done;
  logic signed [OUT_W-1:0] quat_x, quat_y, quat_z, quat_w;
  logic [1:0]              case_code;

  quat_scoreboard quat_sb;
  int             idle_cycles;
  int             sent;

  up_to_direction_quaternion_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .quat_w(quat_w), .case_code(case_code)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // check results and count cycles with no handshake
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        quat_sb.check_result(quat_x, quat_y, quat_z, quat_w, case_code);
      if (done || (start && !busy))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("watchdog expired");
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // start stays high after a request until the next gap or the end of a batch
  task automatic send_request(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    dir_x <= x;
    dir_y <= y;
    dir_z <= z;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    quat_sb.note_request(x, y, z);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_margin(int unsigned m);
    start <= 1'b0;
    while (quat_sb.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    cfg_data <= MARGIN_W'(m);
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    quat_sb.margin = m;
  endtask

  // mostly moderate lengths, sometimes full-scale or tiny components
  function automatic logic signed [15:0] pick_comp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
      default: return $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
    endcase
  endfunction

  task automatic random_batch(int n);
    logic signed [15:0] x, y, z;
    for (int i = 0; i < n; i++) begin
      x = pick_comp();
      y = pick_comp();
      z = pick_comp();
      // steer some requests near the poles
      if ($urandom_range(0, 7) == 0) begin
        x = $signed(16'($urandom_range(0, 6))) - 16'sd3;
        z = $signed(16'($urandom_range(0, 6))) - 16'sd3;
      end
      send_request(x, y, z);
    end
  endtask

  initial begin
    quat_sb = new();
    idle_cycles = 0;
    sent = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    dir_x = '0;
    dir_y = '0;
    dir_z = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(0, 0, 0);
    send_request(0, 100, 0);
    send_request(0, -100, 0);
    send_request(0, 16'sh7fff, 0);
    send_request(0, -16'sh8000, 0);
    send_request(-16'sh8000, -16'sh8000, -16'sh8000);
    send_request(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_request(16'sh7fff, 0, 0);
    send_request(0, 0, -16'sh8000);
    send_request(1, 0, 0);
    send_request(-1, -1, 1);
    send_request(1, 1000, 1);
    send_request(1, -1000, -1);
    send_request(-16'sh8000, 16'sh7fff, 0);
    send_request(16'sh5555, -16'sh2aab, 16'sh1234);

    write_margin(1024);
    send_request(1, 20, 0);
    send_request(1, -20, 0);
    send_request(10, 10, 0);
    send_request(0, 0, 0);
    random_batch(300);
    write_margin(2047);
    random_batch(200);
    write_margin(1);
    random_batch(300);
    write_margin($urandom_range(2, 300));
    random_batch(300);
    write_margin(0);
    random_batch(530);

    start <= 1'b0;
    while (quat_sb.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    $display("%0d requests, %0d results checked: general %0d aligned %0d opposite %0d zero %0d",
             sent, quat_sb.checked, quat_sb.per_code[0], quat_sb.per_code[1],
             quat_sb.per_code[2], quat_sb.per_code[3]);
    $display("margins 0, 1, 1024, 2047 and one random value exercised");
    if (quat_sb.mismatches == 0 && quat_sb.unmatched == 0 && quat_sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

`default_nettype wire

[filelist.f]
rtl/core/utdq_pkg.sv
rtl/core/utdq_queue.sv
rtl/core/utdq_front.sv
rtl/core/utdq_scale.sv
rtl/core/utdq_back.sv
rtl/core/up_to_direction_quaternion_top.sv
bench/tb_up_to_direction_quaternion_top.sv
